>>> hw/rtl/bole_pkg.sv
// package for the bounded ordered list engine
// types, codes and sizes shared by the sequencer and the top level
package bole_pkg;
  localparam int Capacity = 64;
  localparam int AddrW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);

  localparam logic [2:0] ReqInsFront = 3'd0;
  localparam logic [2:0] ReqInsEnd   = 3'd1;
  localparam logic [2:0] ReqInsAtP   = 3'd2;
  localparam logic [2:0] ReqDelFront = 3'd3;
  localparam logic [2:0] ReqDelEnd   = 3'd4;
  localparam logic [2:0] ReqDelAtP   = 3'd5;
  localparam logic [2:0] ReqSearch   = 3'd6;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StFull     = 3'd1;
  localparam logic [2:0] StEmpty    = 3'd2;
  localparam logic [2:0] StBadPos   = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;

  typedef struct packed {
    logic [2:0]        req_type;
    logic signed [31:0] value;
    logic [6:0]        position;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] found_index;
    logic [6:0] length;
  } rsp_t;
endpackage

>>> hw/rtl/bole_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no package dependency
module bole_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> hw/rtl/bounded_ordered_list_engine_unit.sv
// top level of the bounded ordered list engine
// depends on bole_pkg and bole_ram
//
// channel   direction  handshake           payload
// request   in         start_i & !busy_o   req_i (bole_pkg::req_t)
// response  out        done_o (one cycle)  rsp_o (bole_pkg::rsp_t)
//
// an error, a no-op, a search of an empty list or a delete of the last entry go to SDone
// an insert reads and writes each entry that moves, then writes the value into the slot
// a delete reads and writes each entry that moves; a search addresses, then compares, each
// entry; busy_o drops in the cycle after done_o; reset clears the state and the count only,
// no clearing pass; the ram has a single port pair, so entries move one at a time
// the receiver cannot stall
module bounded_ordered_list_engine_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  bole_pkg::req_t  req_i,
  output logic            busy_o,
  output logic            done_o,
  output bole_pkg::rsp_t  rsp_o
);
  import bole_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SRead  = 3'd1;
  localparam logic [2:0] SWrite = 3'd2;
  localparam logic [2:0] SSrch  = 3'd3;
  localparam logic [2:0] SDone  = 3'd4;
  localparam logic [2:0] SCmp   = 3'd5;
  localparam logic [2:0] SPut   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  idx_q, idx_d;   // entry being read
  logic [CntW-1:0]  stop_q, stop_d; // last index of the shift or search
  logic             ins_q, ins_d;   // shift direction
  req_t             req_q, req_d;
  rsp_t             rsp_q, rsp_d;
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0]      wdata, rdata;

  bole_ram #(.Width(32), .Depth(Capacity)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign busy_o = (state_q != SIdle);
  assign done_o = (state_q == SDone);
  assign rsp_o  = rsp_q;
  assign raddr  = idx_q[AddrW-1:0];

  // sequencer: shifts one entry per read/write pair, search one entry per address/compare pair
  always_comb begin
    logic [CntW-1:0] p;
    state_d = state_q; cnt_d = cnt_q; idx_d = idx_q; stop_d = stop_q;
    ins_d = ins_q; req_d = req_q; rsp_d = rsp_q;
    we = 1'b0; waddr = '0; wdata = req_q.value;
    p = req_i.position[CntW-1:0];
    case (state_q)
      SIdle: begin
        if (start_i) begin
          req_d = req_i;
          rsp_d = '{status: StOk, found_index: '0, length: 7'(cnt_q)};
          state_d = SDone;
          case (req_i.req_type)
            ReqInsFront, ReqInsEnd, ReqInsAtP: begin
              if (cnt_q == CntW'(Capacity)) rsp_d.status = StFull;
              else begin
                if (req_i.req_type == ReqInsFront) p = '0;
                else if (req_i.req_type == ReqInsEnd) p = cnt_q;
                if (req_i.req_type == ReqInsAtP && 7'(req_i.position) > 7'(cnt_q))
                  rsp_d.status = StBadPos;
                else begin
                  // move entries cnt-1 down to p up by one, then write p
                  ins_d = 1'b1; stop_d = p;
                  idx_d = cnt_q - CntW'(1);
                  state_d = (cnt_q == p) ? SPut : SRead;
                end
              end
            end
            ReqDelFront, ReqDelEnd, ReqDelAtP: begin
              if (cnt_q == '0) rsp_d.status = StEmpty;
              else begin
                if (req_i.req_type == ReqDelFront) p = '0;
                else if (req_i.req_type == ReqDelEnd) p = cnt_q - CntW'(1);
                if (req_i.req_type == ReqDelAtP && 7'(req_i.position) >= 7'(cnt_q))
                  rsp_d.status = StBadPos;
                else begin
                  // move entries p+1 .. cnt-1 down by one
                  ins_d = 1'b0; stop_d = cnt_q - CntW'(1);
                  idx_d = p + CntW'(1);
                  if (p == cnt_q - CntW'(1)) begin
                    cnt_d = cnt_q - CntW'(1);
                    rsp_d.length = 7'(cnt_q - CntW'(1));
                  end else state_d = SRead;
                end
              end
            end
            ReqSearch: begin
              rsp_d.status = StNotFound;
              if (cnt_q != '0) begin
                idx_d = '0; stop_d = cnt_q - CntW'(1); state_d = SSrch;
              end
            end
            default: ;
          endcase
        end
      end
      SRead: state_d = SWrite;
      SWrite: begin
        we = 1'b1;
        if (ins_q) begin
          // entry idx moves one place up
          waddr = AddrW'(idx_q + CntW'(1)); wdata = rdata;
          if (idx_q == stop_q) state_d = SPut;
          else begin
            idx_d = idx_q - CntW'(1); state_d = SRead;
          end
        end else begin
          waddr = AddrW'(idx_q - CntW'(1)); wdata = rdata;
          if (idx_q == stop_q) begin
            cnt_d = cnt_q - CntW'(1);
            rsp_d.length = 7'(cnt_q - CntW'(1));
            state_d = SDone;
          end else begin
            idx_d = idx_q + CntW'(1); state_d = SRead;
          end
        end
      end
      SPut: begin
        // write of the inserted value into the opened slot
        we = 1'b1;
        waddr = stop_q[AddrW-1:0]; wdata = req_q.value;
        cnt_d = cnt_q + CntW'(1);
        rsp_d.length = 7'(cnt_q + CntW'(1));
        state_d = SDone;
      end
      SSrch: begin
        // the ram returns the data of idx_q in the cycle after its address
        state_d = SCmp;
      end
      SCmp: begin
        if ($signed(rdata) == req_q.value) begin
          rsp_d.status = StOk; rsp_d.found_index = 6'(idx_q); state_d = SDone;
        end else if (idx_q == stop_q) state_d = SDone;
        else begin
          idx_d = idx_q + CntW'(1); state_d = SSrch;
        end
      end
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; stop_q <= stop_d; ins_q <= ins_d;
    req_q <= req_d; rsp_q <= rsp_d;
  end
endmodule
